### rtl/core/psg_pkg.sv
// ----------------------------------------------------------------------------
// psg_pkg
// shared constants, types and helpers of the prime sieve generator
// ----------------------------------------------------------------------------
package psg_pkg;

	localparam int MaxLimit   = 256;
	localparam int FirstPrime = 2;
	localparam int LimitInW   = 9;
	localparam int ValueW     = 8;
	localparam int AddrW      = $clog2(MaxLimit);
	localparam int LimitW     = $clog2(MaxLimit + 1);
	localparam int CntW       = LimitW + 1;
	localparam int RootW      = ($clog2(MaxLimit) + 1) / 2 + 1;
	localparam int SqW        = 2 * RootW;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SV_CHECK,
		ST_SV_WAIT,
		ST_STRIKE,
		ST_SC_READ,
		ST_SC_WAIT,
		ST_FINAL
	} state_t;

	typedef struct packed {
		logic             wr_en;
		logic [AddrW-1:0] wr_addr;
		logic             wr_data;
		logic             rd_en;
		logic [AddrW-1:0] rd_addr;
	} mark_req_t;

	typedef struct packed {
		logic [ValueW-1:0] prime_value;
		logic              found;
		logic              last;
	} result_t;

	function automatic logic [LimitW-1:0] saturate_limit(input logic [LimitInW-1:0] raw);
		logic [LimitW-1:0] res;
		if (raw > LimitInW'(MaxLimit)) begin
			res = LimitW'(MaxLimit);
		end else begin
			res = raw[LimitW-1:0];
		end
		return res;
	endfunction

endpackage

### rtl/core/psg_mark_ram.sv
// ----------------------------------------------------------------------------
// psg_mark_ram
// one-bit-per-number mark store, one write and one registered read port
// ----------------------------------------------------------------------------
module psg_mark_ram (
	input  logic              clk,
	input  psg_pkg::mark_req_t req,
	output logic              rd_data
);
	import psg_pkg::*;

	logic mem [MaxLimit];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

### rtl/core/psg_ctrl.sv
// ----------------------------------------------------------------------------
// psg_ctrl
// sequencer: clear pass, strike of multiples, ascending scan with one held prime
// ----------------------------------------------------------------------------
module psg_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic [psg_pkg::LimitInW-1:0] limit,
	output psg_pkg::mark_req_t           mark_req,
	input  logic                         mark_rd_data,
	output logic                         push_valid,
	input  logic                         push_ready,
	output psg_pkg::result_t             push_data
);
	import psg_pkg::*;

	state_t             state_q, state_d;
	logic [LimitW-1:0]  n_q, n_d;
	logic [CntW-1:0]    cnt_q, cnt_d;
	logic [RootW-1:0]   i_q, i_d;
	logic [ValueW-1:0]  pend_q, pend_d;
	logic               pend_vld_q, pend_vld_d;
	logic [SqW-1:0]     sq;
	logic               sq_below_n;
	logic               cnt_below_n;

	assign sq          = SqW'(i_q) * SqW'(i_q);
	assign sq_below_n  = sq < SqW'(n_q);
	assign cnt_below_n = cnt_q < CntW'(n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pend_vld_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			pend_vld_q <= pend_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		n_q    <= n_d;
		cnt_q  <= cnt_d;
		i_q    <= i_d;
		pend_q <= pend_d;
	end

	always_comb begin
		state_d    = state_q;
		n_d        = n_q;
		cnt_d      = cnt_q;
		i_d        = i_q;
		pend_d     = pend_q;
		pend_vld_d = pend_vld_q;
		req_ready  = 1'b0;
		mark_req   = '0;
		push_valid = 1'b0;
		push_data  = '0;

		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					n_d        = saturate_limit(limit);
					cnt_d      = '0;
					pend_vld_d = 1'b0;
					state_d    = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				mark_req.wr_en   = 1'b1;
				mark_req.wr_addr = cnt_q[AddrW-1:0];
				mark_req.wr_data = 1'b1;
				cnt_d            = cnt_q + CntW'(1);
				if (cnt_q == CntW'(MaxLimit - 1)) begin
					i_d     = RootW'(FirstPrime);
					state_d = ST_SV_CHECK;
				end
			end
			ST_SV_CHECK: begin
				if (sq_below_n) begin
					mark_req.rd_en   = 1'b1;
					mark_req.rd_addr = AddrW'(i_q);
					state_d          = ST_SV_WAIT;
				end else begin
					cnt_d   = CntW'(FirstPrime);
					state_d = ST_SC_READ;
				end
			end
			ST_SV_WAIT: begin
				if (mark_rd_data) begin
					cnt_d   = CntW'(sq);
					state_d = ST_STRIKE;
				end else begin
					i_d     = i_q + RootW'(1);
					state_d = ST_SV_CHECK;
				end
			end
			ST_STRIKE: begin
				if (cnt_below_n) begin
					mark_req.wr_en   = 1'b1;
					mark_req.wr_addr = cnt_q[AddrW-1:0];
					mark_req.wr_data = 1'b0;
					cnt_d            = cnt_q + CntW'(i_q);
				end else begin
					i_d     = i_q + RootW'(1);
					state_d = ST_SV_CHECK;
				end
			end
			ST_SC_READ: begin
				if (cnt_below_n) begin
					mark_req.rd_en   = 1'b1;
					mark_req.rd_addr = cnt_q[AddrW-1:0];
					state_d          = ST_SC_WAIT;
				end else begin
					state_d = ST_FINAL;
				end
			end
			ST_SC_WAIT: begin
				if (!mark_rd_data) begin
					cnt_d   = cnt_q + CntW'(1);
					state_d = ST_SC_READ;
				end else if (!pend_vld_q) begin
					pend_d     = cnt_q[ValueW-1:0];
					pend_vld_d = 1'b1;
					cnt_d      = cnt_q + CntW'(1);
					state_d    = ST_SC_READ;
				end else begin
					// held prime goes out once a later one is known
					push_valid            = 1'b1;
					push_data.prime_value = pend_q;
					push_data.found       = 1'b1;
					push_data.last        = 1'b0;
					if (push_ready) begin
						pend_d  = cnt_q[ValueW-1:0];
						cnt_d   = cnt_q + CntW'(1);
						state_d = ST_SC_READ;
					end
				end
			end
			ST_FINAL: begin
				push_valid            = 1'b1;
				push_data.prime_value = pend_vld_q ? pend_q : '0;
				push_data.found       = pend_vld_q;
				push_data.last        = 1'b1;
				if (push_ready) begin
					pend_vld_d = 1'b0;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/core/prime_sieve_generator.sv
// one request at a time; the next is taken once the last result has left the sequencer
// a request runs a clear pass over the whole mark memory, then tests each root and
// strikes its multiples, then scans each number below the limit for marks
// the mark memory has one write and one read port, and the sequencer uses one at a time
// reset: arst_n clears the sequencer state and the result valid flag; the mark memory
// needs no reset since every request clears it first
// ----------------------------------------------------------------------------
// prime_sieve_generator
// sieve of eratosthenes: emits every prime below the requested limit
// ----------------------------------------------------------------------------
module prime_sieve_generator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic [psg_pkg::LimitInW-1:0] limit,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [psg_pkg::ValueW-1:0]   prime_value,
	output logic                         found,
	output logic                         last
);
	import psg_pkg::*;

	mark_req_t mark_req;
	logic      mark_rd_data;
	logic      push_valid;
	logic      push_ready;
	result_t   push_data;
	logic      res_valid_q;
	result_t   res_q;

	psg_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.limit        (limit),
		.mark_req     (mark_req),
		.mark_rd_data (mark_rd_data),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_data    (push_data)
	);

	psg_mark_ram u_mark_ram (
		.clk     (clk),
		.req     (mark_req),
		.rd_data (mark_rd_data)
	);

	assign push_ready = !res_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (push_valid && push_ready) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid && push_ready) begin
			res_q <= push_data;
		end
	end

	assign res_valid   = res_valid_q;
	assign prime_value = res_q.prime_value;
	assign found       = res_q.found;
	assign last        = res_q.last;

`ifndef SYNTHESIS
	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one still in progress");

	a_not_found_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !found |-> last)
		else $error("empty result not flagged as last");

	a_found_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && found |-> prime_value >= ValueW'(FirstPrime))
		else $error("prime value below two");

	a_no_push_while_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !push_valid)
		else $error("result pushed while idle");
`endif

endmodule
